// ===== design/ripp_pkg.sv =====
package ripp_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 128;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [2:0] CSR_IMG_COLS = 3'd0;
   localparam logic [2:0] CSR_IMG_ROWS = 3'd1;
   localparam logic [2:0] CSR_CENTER_X = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y = 3'd3;
   localparam logic [2:0] CSR_FOCAL_X  = 3'd4;
   localparam logic [2:0] CSR_FOCAL_Y  = 3'd5;

   localparam logic OP_PROJECT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [1:0] KIND_PROJ     = 2'd0;
   localparam logic [1:0] KIND_READ     = 2'd1;
   localparam logic [1:0] KIND_READ_OOB = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [16:0]        pix;
   } item_type;

endpackage

// ===== design/ripp_front.sv =====
module ripp_front
   import ripp_pkg::*;
#(
   parameter int STORE_DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [16:0]        req_pixel_index,
   input  logic               hold,
   output logic               head_valid,
   output item_type           head_item,
   input  logic               head_pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;
   item_type        new_item;
   logic            push, pop;

   always_comb begin
      new_item.px  = req_point_x;
      new_item.py  = req_point_y;
      new_item.pz  = req_point_z;
      new_item.pix = req_pixel_index;
      if (req_opcode == OP_READ) begin
         if (32'(req_pixel_index) >= 32'(STORE_DEPTH)) begin
            new_item.kind = KIND_READ_OOB;
         end else begin
            new_item.kind = KIND_READ;
         end
      end else begin
         new_item.kind = KIND_PROJ;
      end
   end

   assign req_ready  = (cnt_ff != (PW+1)'(QUEUE_DEPTH)) && !hold;
   // zero forward points are dropped here
   assign push = req_valid && req_ready &&
                 !(req_opcode == OP_PROJECT && req_point_x == 32'sd0);
   assign head_valid = (cnt_ff != '0);
   assign head_item  = q_ff[rd_ff];
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ===== design/ripp_div.sv =====
module ripp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        busy,
   output logic [63:0] quo
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, quo_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== design/ripp_back.sv =====
module ripp_back
   import ripp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        head_pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_range_out
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int XW    = CW + RW + 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_PROJ = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_IDX  = 4'd6;
   localparam logic [3:0] S_MRD  = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_RESP = 4'd9;

   logic [31:0] mem [DEPTH];
   logic [31:0] mem_q_ff;

   logic [3:0]         state_ff, state_in;
   item_type           item_ff, item_in;
   logic [2:0]         mcnt_ff, mcnt_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] pcol_ff, pcol_in, prow_ff, prow_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        sqn_ff, sqn_in, sqr_ff, sqr_in, sqb_ff, sqb_in;
   logic signed [65:0] ucol_ff, ucol_in, urow_ff, urow_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rspv_ff, rspv_in;
   logic [31:0]        rspd_ff, rspd_in;

   logic [10:0]        img_cols_ff;
   logic [7:0]         img_rows_ff;
   logic signed [31:0] cx_ff, cy_ff, fx_ff, fy_ff;

   logic signed [31:0] mul_a, mul_b;
   logic               div_start, dc_busy, dr_busy;
   logic [63:0]        dc_quo, dr_quo, dc_num, dr_num;
   logic [31:0]        den;
   logic [64:0]        sq_sum;
   logic [CW-1:0]      cols;
   logic [RW-1:0]      rows;
   logic signed [65:0] col_lim, row_lim, qc, qr;
   logic [XW-1:0]      flat;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_addr;
   logic [31:0]        mem_wd;

   assign cols = (32'(img_cols_ff) >= 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(img_cols_ff);
   assign rows = (32'(img_rows_ff) >= 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(img_rows_ff);
   assign col_lim = $signed(66'(cols) << 16);
   assign row_lim = $signed(66'(rows) << 16);
   assign flat = XW'(row_ff) * XW'(cols) + XW'(col_ff);

   always_comb begin
      unique case (mcnt_ff)
         3'd0: begin mul_a = fx_ff;      mul_b = item_ff.py; end
         3'd1: begin mul_a = fy_ff;      mul_b = item_ff.pz; end
         3'd2: begin mul_a = item_ff.px; mul_b = item_ff.px; end
         3'd3: begin mul_a = item_ff.py; mul_b = item_ff.py; end
         default: begin mul_a = item_ff.pz; mul_b = item_ff.pz; end
      endcase
   end

   assign dc_num = pcol_ff[63] ? 64'(-pcol_ff) : 64'(pcol_ff);
   assign dr_num = prow_ff[63] ? 64'(-prow_ff) : 64'(prow_ff);
   assign den    = item_ff.px[31] ? 32'(-item_ff.px) : 32'(item_ff.px);
   assign qc     = (pcol_ff[63] ^ item_ff.px[31]) ? -$signed({2'b00, dc_quo})
                                                  : $signed({2'b00, dc_quo});
   assign qr     = (prow_ff[63] ^ item_ff.px[31]) ? -$signed({2'b00, dr_quo})
                                                  : $signed({2'b00, dr_quo});
   assign sq_sum = {1'b0, sqr_ff} + {1'b0, sqb_ff};

   ripp_div u_div_col (
      .clock (clock), .reset (reset), .start (div_start),
      .num (dc_num), .den (den), .busy (dc_busy), .quo (dc_quo)
   );

   ripp_div u_div_row (
      .clock (clock), .reset (reset), .start (div_start),
      .num (dr_num), .den (den), .busy (dr_busy), .quo (dr_quo)
   );

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      mcnt_in   = mcnt_ff;
      prod_in   = prod_ff;
      pcol_in   = pcol_ff;
      prow_in   = prow_ff;
      acc_in    = acc_ff;
      sqn_in    = sqn_ff;
      sqr_in    = sqr_ff;
      sqb_in    = sqb_ff;
      ucol_in   = ucol_ff;
      urow_in   = urow_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      rspv_in   = rspv_ff && !rsp_ready;
      rspd_in   = rspd_ff;
      head_pop  = 1'b0;
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = addr_ff;
      mem_wd    = '0;

      // root iteration runs whenever a bit is left
      if (sqb_ff != '0) begin
         if ({1'b0, sqn_ff} >= sq_sum) begin
            sqn_in = 64'({1'b0, sqn_ff} - sq_sum);
            sqr_in = (sqr_ff >> 1) + sqb_ff;
         end else begin
            sqr_in = sqr_ff >> 1;
         end
         sqb_in = sqb_ff >> 2;
      end

      unique case (state_ff)
         S_CLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               item_in  = head_item;
               addr_in  = AW'(head_item.pix);
               mcnt_in  = '0;
               acc_in   = '0;
               unique case (head_item.kind)
                  KIND_PROJ:     state_in = S_MUL;
                  KIND_READ:     state_in = S_MRD;
                  default:       state_in = S_RESP;
               endcase
            end
         end
         S_MUL: begin
            prod_in = mul_a * mul_b;
            mcnt_in = mcnt_ff + 1'b1;
            unique case (mcnt_ff)
               3'd1: pcol_in = prod_ff;
               3'd2: prow_in = prod_ff;
               3'd3, 3'd4: acc_in = acc_ff + 64'(prod_ff);
               3'd5: begin
                  sqn_in    = acc_ff + 64'(prod_ff);
                  sqr_in    = '0;
                  sqb_in    = 64'd1 << 62;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (!dc_busy && !dr_busy && sqb_ff == '0) begin
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            ucol_in  = 66'(cx_ff) - qc;
            urow_in  = 66'(cy_ff) - qr;
            state_in = S_CHK;
         end
         S_CHK: begin
            col_in = ucol_ff[65] ? '0 : ucol_ff[16+CW-1:16];
            row_in = urow_ff[65] ? '0 : urow_ff[16+RW-1:16];
            if (ucol_ff > -66'sd65536 && ucol_ff < col_lim &&
                urow_ff > -66'sd65536 && urow_ff < row_lim) begin
               state_in = S_IDX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_IDX: begin
            addr_in  = AW'(flat);
            state_in = S_MRD;
         end
         S_MRD: begin
            mem_re   = 1'b1;
            state_in = (item_ff.kind == KIND_PROJ) ? S_UPD : S_RESP;
         end
         S_UPD: begin
            if (mem_q_ff == '0 || sqr_ff[31:0] < mem_q_ff) begin
               mem_we = 1'b1;
               mem_wd = sqr_ff[31:0];
            end
            state_in = S_IDLE;
         end
         S_RESP: begin
            if (!rspv_ff || rsp_ready) begin
               rspv_in = 1'b1;
               if (item_ff.kind == KIND_READ) begin
                  rspd_in = mem_q_ff;
                  mem_we  = 1'b1;
               end else begin
                  rspd_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         sqb_ff      <= '0;
         rspv_ff     <= 1'b0;
         img_cols_ff <= 11'd1024;
         img_rows_ff <= 8'd64;
         cx_ff       <= 32'sd33554432;
         cy_ff       <= 32'sd2097152;
         fx_ff       <= 32'sd65536;
         fy_ff       <= 32'sd65536;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sqb_ff   <= sqb_in;
         rspv_ff  <= rspv_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_IMG_COLS: img_cols_ff <= csr_data[10:0];
               CSR_IMG_ROWS: img_rows_ff <= csr_data[7:0];
               CSR_CENTER_X: cx_ff       <= csr_data;
               CSR_CENTER_Y: cy_ff       <= csr_data;
               CSR_FOCAL_X:  fx_ff       <= csr_data;
               CSR_FOCAL_Y:  fy_ff       <= csr_data;
               default: ;
            endcase
         end
      end
      item_ff <= item_in;
      mcnt_ff <= mcnt_in;
      prod_ff <= prod_in;
      pcol_ff <= pcol_in;
      prow_ff <= prow_in;
      acc_ff  <= acc_in;
      sqn_ff  <= sqn_in;
      sqr_ff  <= sqr_in;
      ucol_ff <= ucol_in;
      urow_ff <= urow_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      addr_ff <= addr_in;
      rspd_ff <= rspd_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   assign clearing      = (state_ff == S_CLR);
   assign rsp_valid     = rspv_ff;
   assign rsp_range_out = rspd_ff;

endmodule

// ===== design/range_image_point_projection_core.sv =====
// Projects Q16.16 points through a pinhole model into a minimum-range image
// and reads pixels back with clear-on-read. Beats queue in a four-entry front
// queue; the back engine works one beat at a time. A project beat passes the
// five-product shared multiplier and then the two 64-step bit-serial dividers,
// with the 32-step square root running beside them; a point outside the image
// skips the store access. A read beat goes through the registered store port,
// a read beyond the store skips it, and a stalled result holds the engine.
// Zero forward points are dropped at the front and cost no back time. After
// reset the range store is cleared one entry a cycle, all MAX_COLS*MAX_ROWS
// entries (131072 by default), while req_ready stays low; configuration
// writes are taken at any time.
module range_image_point_projection_core
   import ripp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [16:0]        req_pixel_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_range_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   item_type head_item;
   logic     head_valid, head_pop, clearing;

   assign csr_ready = 1'b1;

   ripp_front #(
      .STORE_DEPTH (MAX_COLS * MAX_ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_pixel_index (req_pixel_index),
      .hold            (clearing),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop)
   );

   ripp_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_range_out (rsp_range_out)
   );

endmodule

// ===== tb/sv/range_image_point_projection_core_tb.sv =====
module range_image_point_projection_core_tb
   import ripp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int STORE_DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF;
   localparam int SETTLE_CYCLES = 500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = OP_PROJECT;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic [16:0]        req_pixel_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_range_out;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   range_image_point_projection_core dut (.*);

   always #6 clock = ~clock;

   // predicted block state
   bit [31:0] range_mem [int];
   int        cfg_cols = 1024, cfg_rows = 64;
   int        cfg_cx = 33554432, cfg_cy = 2097152, cfg_fx = 65536, cfg_fy = 65536;
   bit [31:0] range_expected [$];
   int        hit_pixels [$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_cycles = 0;
   int  errors = 0;
   int  n_proj = 0, n_read = 0, n_hits = 0, n_rsp = 0;

   function automatic longint pixel_axis(int ctr, int focal, int coord, int px);
      longint prod, quot, pos;
      prod = longint'(focal) * longint'(coord);
      quot = prod / longint'(px);
      pos  = longint'(ctr) - quot;
      return pos / 65536;
   endfunction

   function automatic bit [31:0] point_norm(int x, int y, int z);
      longint ax, ay, az;
      bit [63:0] sq, t;
      bit [31:0] r;
      ax = (x < 0) ? -longint'(x) : longint'(x);
      ay = (y < 0) ? -longint'(y) : longint'(y);
      az = (z < 0) ? -longint'(z) : longint'(z);
      sq = 64'(ax * ax) + 64'(ay * ay) + 64'(az * az);
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = {32'd0, r | (32'd1 << i)};
         if (t * t <= sq) r = r | (32'd1 << i);
      end
      return r;
   endfunction

   task automatic predict_beat(logic op, int x, int y, int z, int pix);
      longint col, row, cols, rows;
      int idx;
      bit [31:0] nrm;
      if (op == OP_READ) begin
         n_read++;
         if (pix >= STORE_DEPTH) begin
            range_expected.insert(range_expected.size(), 32'd0);
         end else begin
            range_expected.insert(range_expected.size(),
                                  range_mem.exists(pix) ? range_mem[pix] : 32'd0);
            range_mem[pix] = 32'd0;
         end
         return;
      end
      n_proj++;
      if (x == 0) return;
      cols = (cfg_cols < MAX_COLS_DEF) ? cfg_cols : MAX_COLS_DEF;
      rows = (cfg_rows < MAX_ROWS_DEF) ? cfg_rows : MAX_ROWS_DEF;
      col = pixel_axis(cfg_cx, cfg_fx, y, x);
      row = pixel_axis(cfg_cy, cfg_fy, z, x);
      if (col < 0 || row < 0 || col >= cols || row >= rows) return;
      idx = int'(row * cols + col);
      if (idx >= STORE_DEPTH) return;
      nrm = point_norm(x, y, z);
      n_hits++;
      if (!range_mem.exists(idx) || range_mem[idx] == 0 || nrm < range_mem[idx])
         range_mem[idx] = nrm;
      hit_pixels.insert(hit_pixels.size(), idx);
      if (hit_pixels.size() > 64) void'(hit_pixels.pop_front());
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (range_expected.size() == 0) begin
            errors++;
            $display("%0t unexpected result beat: expected none, actual %h", $time,
                     rsp_range_out);
         end else begin
            if (rsp_range_out !== range_expected[0]) begin
               errors++;
               $display("%0t range_out mismatch: expected %h, actual %h", $time,
                        range_expected[0], rsp_range_out);
            end
            void'(range_expected.pop_front());
         end
      end
   end

   // receiver with random stalls and long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_beat(logic op, int x, int y, int z, int pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_point_x     <= x;
      req_point_y     <= y;
      req_point_z     <= z;
      req_pixel_index <= pix[16:0];
      do @(posedge clock); while (!req_ready);
      predict_beat(op, x, y, z, pix & 32'h1ffff);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, int data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_IMG_COLS: cfg_cols = data & 32'h7ff;
         CSR_IMG_ROWS: cfg_rows = data & 32'hff;
         CSR_CENTER_X: cfg_cx = data;
         CSR_CENTER_Y: cfg_cy = data;
         CSR_FOCAL_X:  cfg_fx = data;
         CSR_FOCAL_Y:  cfg_fy = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(int cols, int rows, int cx, int cy, int fx, int fy);
      write_reg(CSR_IMG_COLS, cols);
      write_reg(CSR_IMG_ROWS, rows);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_FOCAL_X, fx);
      write_reg(CSR_FOCAL_Y, fy);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (range_expected.size() != 0 && guard < 2000000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // point aimed inside the current image (exact for unit focal lengths)
   task automatic send_aimed_point(int cols, int rows);
      int px, c, r, offc, offr;
      longint py, pz;
      px = $urandom_range(1, 1 << 18);
      if ($urandom_range(9) == 0) px = -px;
      c = (cols > 1) ? $urandom_range(cols - 1) : 0;
      r = (rows > 1) ? $urandom_range(rows - 1) : 0;
      if ($urandom_range(3) == 0) begin
         c = c % 4;
         r = r % 2;
      end
      offc = (cfg_cx >>> 16) - c;
      offr = (cfg_cy >>> 16) - r;
      py = longint'(px) * offc + $urandom_range(255);
      pz = longint'(px) * offr + $urandom_range(255);
      send_beat(OP_PROJECT, px, int'(py), int'(pz), $urandom);
   endtask

   task automatic send_read_back;
      int pix;
      if (hit_pixels.size() != 0 && $urandom_range(9) < 7)
         pix = hit_pixels[$urandom_range(hit_pixels.size() - 1)];
      else
         pix = $urandom_range(131071);
      send_beat(OP_READ, $urandom, $urandom, $urandom, pix);
   endtask

   task automatic random_mix(int count, int cols, int rows);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 55) send_aimed_point(cols, rows);
         else if (sel < 85) send_read_back();
         else if (sel < 90) send_beat(OP_PROJECT, 0, $urandom, $urandom, $urandom);
         else send_beat(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic test_directed;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_beat(OP_PROJECT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
      send_beat(OP_PROJECT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 131071);
      send_beat(OP_PROJECT, 32'sh7fffffff, 32'sh80000000, 0, 0);
      send_beat(OP_PROJECT, 0, 65536, 65536, 0);
      send_beat(OP_PROJECT, 65536, 32'sh7fffffff, 0, 0);
      // lands in (-1,0), truncates to column 0
      send_beat(OP_PROJECT, 65536, 33587200, 0, 0);
      send_beat(OP_PROJECT, 65536, 0, 0, 0);
      send_beat(OP_PROJECT, 131072, 0, 0, 0);
      send_beat(OP_PROJECT, 32768, 0, 0, 0);
      send_beat(OP_PROJECT, -65536, 0, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 32 * 1024 + 512);
      send_beat(OP_READ, 0, 0, 0, 32 * 1024 + 512);
      send_beat(OP_READ, 0, 0, 0, 32 * 1024);
      send_beat(OP_READ, 32'sh7fffffff, 32'sh80000000, 32'shffffffff, 131071);
      send_beat(OP_READ, 0, 0, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 100000);
      drain();
      // store entries survive a config change
      set_config(1, 1, 0, 0, 65536, 65536);
      send_beat(OP_PROJECT, 65536, 0, 0, 0);
      send_beat(OP_PROJECT, 65536, 65536, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 0);
      drain();
      write_reg(CSR_SPARE, 32'hffffffff);
      write_reg(CSR_UNUSED, 32'h12345678);
      set_config(0, 0, 0, 0, 65536, 65536);
      send_beat(OP_PROJECT, 65536, 0, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_extreme_config;
      set_config(2047, 255, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      random_mix(30, 1024, 128);
      drain();
      set_config(1024, 128, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      random_mix(30, 1024, 128);
      drain();
   endtask

   task automatic test_random_phases;
      send_idle_pct = 0;  rsp_stall_pct = 0;
      set_config(1024, 64, 33554432, 2097152, 65536, 65536);
      random_mix(180, 1024, 64);
      drain();
      send_idle_pct = 88; rsp_stall_pct = 0;
      set_config(16, 8, 8 << 16, 4 << 16, 65536, 65536);
      random_mix(150, 16, 8);
      drain();
      send_idle_pct = 0;  rsp_stall_pct = 88;
      set_config(1024, 128, 512 << 16, 64 << 16, 131072, -65536);
      random_mix(150, 1024, 128);
      drain();
      send_idle_pct = 34; rsp_stall_pct = 34;
      set_config(4, 2, 2 << 16, 1 << 16, 65536, 65536);
      random_mix(150, 4, 2);
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      hold_cycles = 3000;
      for (int i = 0; i < 40; i++) begin
         if (i % 4 == 0) send_aimed_point(4, 2);
         else send_read_back();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_extreme_config();
      test_random_phases();
      test_backpressure();
      drain();
      if (range_expected.size() != 0) begin
         errors++;
         $display("%0t leftover expectations: expected 0, actual %0d", $time,
                  range_expected.size());
      end
      $display("covered %0d project beats (%0d in image) and %0d reads, %0d results",
               n_proj, n_hits, n_read, n_rsp);
      $display("over extreme and random configs with idle, stall and hold-off phases");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
